>>> sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property checked at every rising edge outside reset
`define PAH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");
// condition that must never hold outside reset
`define PAH_NEVER(lbl, clk, rst_n, cond) \
	`PAH_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define PAH_ASSERT(lbl, clk, rst_n, prop)
`define PAH_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> sv/pah_pkg.sv
// types and constants of the pressure alarm
package pah_pkg;

	localparam int AVG_W   = 14;
	localparam int LIMIT_W = 45;
	localparam int FIELD_W = 15;
	localparam int RES_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int HOLD_REG_W = 4;

	// lowered threshold: limit minus 5.00 but never below 1.00
	localparam logic [AVG_W-1:0] PENALTY       = 14'd500;
	localparam logic [AVG_W-1:0] PENALTY_FLOOR = 14'd100;

	localparam logic [LIMIT_W-1:0] CPU_SOME_RESET = 45'd21384;
	localparam logic [LIMIT_W-1:0] MEM_SOME_RESET = 45'd17384;
	localparam logic [LIMIT_W-1:0] MEM_FULL_RESET = 45'd0;
	localparam logic [LIMIT_W-1:0] IO_SOME_RESET  = 45'd0;
	localparam logic [LIMIT_W-1:0] IO_FULL_RESET  = 45'd17884;
	localparam logic [HOLD_REG_W-1:0] HOLD_RESET  = 4'd2;

	typedef enum logic [1:0] {
		CLS_INACTIVE    = 2'd0,
		CLS_STABILISING = 2'd1,
		CLS_ACTIVE      = 2'd2,
		CLS_ERROR       = 2'd3
	} cls_t;

	typedef enum logic [RES_W-1:0] {
		RES_CPU    = 2'd0,
		RES_MEMORY = 2'd1,
		RES_IO     = 2'd2
	} res_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CPU_SOME = 3'd0,
		REG_MEM_SOME = 3'd1,
		REG_MEM_FULL = 3'd2,
		REG_IO_SOME  = 3'd3,
		REG_IO_FULL  = 3'd4,
		REG_HOLD     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] cpu_some;
		logic [LIMIT_W-1:0] mem_some;
		logic [LIMIT_W-1:0] mem_full;
		logic [LIMIT_W-1:0] io_some;
		logic [LIMIT_W-1:0] io_full;
	} limits_t;

	typedef struct packed {
		logic [RES_W-1:0] resource;
		logic             reading_valid;
		logic [AVG_W-1:0] some_short;
		logic [AVG_W-1:0] some_mid;
		logic [AVG_W-1:0] some_long;
		logic [AVG_W-1:0] full_short;
		logic [AVG_W-1:0] full_mid;
		logic [AVG_W-1:0] full_long;
	} reading_t;

	typedef struct packed {
		logic [RES_W-1:0] resource_out;
		cls_t             reading_class;
		cls_t             alert_state;
		logic             open_alert;
		logic             close_alert;
	} result_t;

endpackage

>>> sv/pah_reading_if.sv
// input and result channels of the pressure alarm
interface pah_reading_if;
	logic        valid;
	logic        ready;
	logic [1:0]  resource;
	logic        reading_valid;
	logic [13:0] some_short;
	logic [13:0] some_mid;
	logic [13:0] some_long;
	logic [13:0] full_short;
	logic [13:0] full_mid;
	logic [13:0] full_long;

	modport source (
		output valid, resource, reading_valid, some_short, some_mid, some_long,
		full_short, full_mid, full_long,
		input ready
	);
	modport sink (
		input valid, resource, reading_valid, some_short, some_mid, some_long,
		full_short, full_mid, full_long,
		output ready
	);
endinterface

interface pah_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] resource_out;
	logic [1:0] reading_class;
	logic [1:0] alert_state;
	logic       open_alert;
	logic       close_alert;

	modport source (
		output valid, resource_out, reading_class, alert_state, open_alert, close_alert,
		input ready
	);
	modport sink (
		input valid, resource_out, reading_class, alert_state, open_alert, close_alert,
		output ready
	);
endinterface

>>> sv/pressure_alarm_with_hysteresis.sv
// top level of the pressure alarm with hysteresis and hold-off
// Accepts one pressure reading per clock cycle with no gaps while result.ready
// is high; each reading gives one result, written to the output register as the
// reading leaves the input register. Between the two registers a single
// stage classifies the reading against the configured thresholds and updates the
// alert state, hold-off counter and open-alert flag of its resource, so a reading
// always sees the state left by the one before it. A result held in the output
// register by a low result.ready keeps the next reading in the input register, and
// once both registers are full the input is stalled until the result is taken.
// Configuration must be written via cfg_we/cfg_index/cfg_wdata while no reading
// is in flight (not enforced by the block); no clearing pass is needed after reset.
module pressure_alarm_with_hysteresis #(
	parameter int RESOURCE_COUNT = 3,
	parameter int HOLD_WIDTH     = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pah_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pah_pkg::LIMIT_W-1:0]      cfg_wdata,
	pah_reading_if.sink                      reading,
	pah_result_if.source                     result
);

`include "assert_macros.svh"

	localparam int IDX_W    = (RESOURCE_COUNT > 1) ? $clog2(RESOURCE_COUNT) : 1;
	localparam int HOLD_MAX = (1 << HOLD_WIDTH) - 1;

	pah_pkg::limits_t                 limits_q;
	logic [pah_pkg::HOLD_REG_W-1:0]   hold_q;

	logic              valid_s1;
	pah_pkg::reading_t rd_s1;
	logic              out_valid_q;
	pah_pkg::result_t  res_q;

	pah_pkg::cls_t           last_state_q [RESOURCE_COUNT];
	logic [HOLD_WIDTH-1:0]   hold_left_q  [RESOURCE_COUNT];
	logic                    alert_open_q [RESOURCE_COUNT];

	logic                  advance;
	logic                  known;
	logic [IDX_W-1:0]      idx;
	pah_pkg::cls_t         cls;
	pah_pkg::cls_t         cur_state;
	logic [HOLD_WIDTH-1:0] cur_hold;
	logic                  cur_open;
	logic [HOLD_WIDTH-1:0] hold_init;
	pah_pkg::cls_t         nxt_state;
	logic [HOLD_WIDTH-1:0] nxt_hold;
	logic                  nxt_open;
	logic                  open_ev;
	logic                  close_ev;
	logic                  upd;
	pah_pkg::result_t      res_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.cpu_some <= pah_pkg::CPU_SOME_RESET;
			limits_q.mem_some <= pah_pkg::MEM_SOME_RESET;
			limits_q.mem_full <= pah_pkg::MEM_FULL_RESET;
			limits_q.io_some  <= pah_pkg::IO_SOME_RESET;
			limits_q.io_full  <= pah_pkg::IO_FULL_RESET;
			hold_q            <= pah_pkg::HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pah_pkg::REG_CPU_SOME: limits_q.cpu_some <= cfg_wdata;
				pah_pkg::REG_MEM_SOME: limits_q.mem_some <= cfg_wdata;
				pah_pkg::REG_MEM_FULL: limits_q.mem_full <= cfg_wdata;
				pah_pkg::REG_IO_SOME:  limits_q.io_some  <= cfg_wdata;
				pah_pkg::REG_IO_FULL:  limits_q.io_full  <= cfg_wdata;
				pah_pkg::REG_HOLD:     hold_q <= cfg_wdata[pah_pkg::HOLD_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: input register moves on when the output register is free or drains
	assign advance       = valid_s1 && (!out_valid_q || result.ready);
	assign reading.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (reading.ready) begin
			valid_s1 <= reading.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (reading.valid && reading.ready) begin
			rd_s1.resource      <= reading.resource;
			rd_s1.reading_valid <= reading.reading_valid;
			rd_s1.some_short    <= reading.some_short;
			rd_s1.some_mid      <= reading.some_mid;
			rd_s1.some_long     <= reading.some_long;
			rd_s1.full_short    <= reading.full_short;
			rd_s1.full_mid      <= reading.full_mid;
			rd_s1.full_long     <= reading.full_long;
		end
	end

	pah_eval u_eval (
		.limits (limits_q),
		.rd     (rd_s1),
		.cls    (cls)
	);

	assign known = (rd_s1.resource != 2'd3) && (32'(rd_s1.resource) < RESOURCE_COUNT);
	assign idx   = IDX_W'(rd_s1.resource);

	always_comb begin
		if (known) begin
			cur_state = last_state_q[idx];
			cur_hold  = hold_left_q[idx];
			cur_open  = alert_open_q[idx];
		end else begin
			cur_state = pah_pkg::CLS_INACTIVE;
			cur_hold  = '0;
			cur_open  = 1'b0;
		end
	end

	// hold interval: zero counts as one, saturates at the counter's maximum
	always_comb begin
		if (hold_q == '0)
			hold_init = HOLD_WIDTH'(1);
		else if (32'(hold_q) > HOLD_MAX)
			hold_init = HOLD_WIDTH'(HOLD_MAX);
		else
			hold_init = HOLD_WIDTH'(32'(hold_q));
	end

	always_comb begin
		nxt_state = cur_state;
		nxt_hold  = cur_hold;
		nxt_open  = cur_open;
		open_ev   = 1'b0;
		close_ev  = 1'b0;
		case (cls)
			pah_pkg::CLS_ACTIVE: begin
				if (cur_state != pah_pkg::CLS_ACTIVE) begin
					nxt_hold = hold_init;
					if (!cur_open) begin
						nxt_open = 1'b1;
						open_ev  = 1'b1;
					end
				end
				nxt_state = pah_pkg::CLS_ACTIVE;
			end
			pah_pkg::CLS_STABILISING: begin
				nxt_state = pah_pkg::CLS_STABILISING;
			end
			default: begin
				if (cur_state == pah_pkg::CLS_INACTIVE) begin
					nxt_state = pah_pkg::CLS_INACTIVE;
				end else if (cur_hold > HOLD_WIDTH'(1)) begin
					nxt_hold  = cur_hold - HOLD_WIDTH'(1);
					nxt_state = pah_pkg::CLS_STABILISING;
				end else begin
					// counter of one or less closes the alert at once
					nxt_hold  = '0;
					close_ev  = cur_open;
					nxt_open  = 1'b0;
					nxt_state = pah_pkg::CLS_INACTIVE;
				end
			end
		endcase
	end

	assign upd = advance && known && rd_s1.reading_valid;

	always_comb begin
		res_d.resource_out = rd_s1.resource;
		if (!known) begin
			res_d.reading_class = pah_pkg::CLS_ERROR;
			res_d.alert_state   = pah_pkg::CLS_INACTIVE;
			res_d.open_alert    = 1'b0;
			res_d.close_alert   = 1'b0;
		end else if (!rd_s1.reading_valid) begin
			res_d.reading_class = pah_pkg::CLS_ERROR;
			res_d.alert_state   = cur_state;
			res_d.open_alert    = 1'b0;
			res_d.close_alert   = 1'b0;
		end else begin
			res_d.reading_class = cls;
			res_d.alert_state   = nxt_state;
			res_d.open_alert    = open_ev;
			res_d.close_alert   = close_ev;
		end
	end

	// per-resource alert state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RESOURCE_COUNT; i++) begin
				last_state_q[i] <= pah_pkg::CLS_INACTIVE;
				hold_left_q[i]  <= '0;
				alert_open_q[i] <= 1'b0;
			end
		end else if (upd) begin
			last_state_q[idx] <= nxt_state;
			hold_left_q[idx]  <= nxt_hold;
			alert_open_q[idx] <= nxt_open;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_d;
	end

	assign result.valid         = out_valid_q;
	assign result.resource_out  = res_q.resource_out;
	assign result.reading_class = res_q.reading_class;
	assign result.alert_state   = res_q.alert_state;
	assign result.open_alert    = res_q.open_alert;
	assign result.close_alert   = res_q.close_alert;

	`PAH_NEVER(a_open_close_excl, clk, arst_n, out_valid_q && res_q.open_alert && res_q.close_alert)
	`PAH_ASSERT(a_open_is_active, clk, arst_n, (out_valid_q && res_q.open_alert) |-> (res_q.reading_class == pah_pkg::CLS_ACTIVE && res_q.alert_state == pah_pkg::CLS_ACTIVE))
	`PAH_ASSERT(a_close_is_inactive, clk, arst_n, (out_valid_q && res_q.close_alert) |-> (res_q.reading_class == pah_pkg::CLS_INACTIVE && res_q.alert_state == pah_pkg::CLS_INACTIVE))
	`PAH_NEVER(a_error_no_event, clk, arst_n, out_valid_q && res_q.reading_class == pah_pkg::CLS_ERROR && (res_q.open_alert || res_q.close_alert))
	`PAH_ASSERT(a_update_lands, clk, arst_n, upd |=> out_valid_q)

endmodule

>>> sv/pah_eval.sv
// threshold classification of one reading against its resource's limits
module pah_eval (
	input  pah_pkg::limits_t  limits,
	input  pah_pkg::reading_t rd,
	output pah_pkg::cls_t     cls
);

	function automatic logic [pah_pkg::AVG_W-1:0] lowered(
		input logic [pah_pkg::AVG_W-1:0] thr
	);
		logic [pah_pkg::AVG_W-1:0] low;
		if (thr < pah_pkg::PENALTY + pah_pkg::PENALTY_FLOOR)
			low = pah_pkg::PENALTY_FLOOR;
		else
			low = thr - pah_pkg::PENALTY;
		return low;
	endfunction

	function automatic pah_pkg::cls_t classify_line(
		input logic [pah_pkg::LIMIT_W-1:0] lim,
		input logic [pah_pkg::AVG_W-1:0]   a0,
		input logic [pah_pkg::AVG_W-1:0]   a1,
		input logic [pah_pkg::AVG_W-1:0]   a2
	);
		logic [2:0][pah_pkg::AVG_W-1:0] avg;
		logic [pah_pkg::FIELD_W-1:0]    f;
		logic [pah_pkg::AVG_W-1:0]      thr;
		logic                           act;
		logic                           stab;
		pah_pkg::cls_t                  c;
		avg  = {a2, a1, a0};
		act  = 1'b0;
		stab = 1'b0;
		for (int k = 0; k < 3; k++) begin
			f   = lim[k*pah_pkg::FIELD_W +: pah_pkg::FIELD_W];
			thr = f[pah_pkg::AVG_W-1:0];
			if (f[pah_pkg::FIELD_W-1]) begin
				if (avg[k] > thr)
					act = 1'b1;
				if (avg[k] > lowered(thr))
					stab = 1'b1;
			end
		end
		if (act)
			c = pah_pkg::CLS_ACTIVE;
		else if (stab)
			c = pah_pkg::CLS_STABILISING;
		else
			c = pah_pkg::CLS_INACTIVE;
		return c;
	endfunction

	logic [pah_pkg::LIMIT_W-1:0] some_lim;
	logic [pah_pkg::LIMIT_W-1:0] full_lim;
	pah_pkg::cls_t               some_cls;
	pah_pkg::cls_t               full_cls;

	always_comb begin
		case (rd.resource)
			pah_pkg::RES_CPU: begin
				some_lim = limits.cpu_some;
				full_lim = '0;
			end
			pah_pkg::RES_MEMORY: begin
				some_lim = limits.mem_some;
				full_lim = limits.mem_full;
			end
			default: begin
				some_lim = limits.io_some;
				full_lim = limits.io_full;
			end
		endcase
	end

	assign some_cls = classify_line(some_lim, rd.some_short, rd.some_mid, rd.some_long);
	assign full_cls = classify_line(full_lim, rd.full_short, rd.full_mid, rd.full_long);

	// full line only counts for memory and io, and only when some is quiet
	always_comb begin
		if (some_cls == pah_pkg::CLS_INACTIVE && rd.resource != pah_pkg::RES_CPU)
			cls = full_cls;
		else
			cls = some_cls;
	end

endmodule
